// ----- rtl/lutf_pkg.sv -----
package lutf_pkg;

  typedef enum logic [1:0] {
    ENC_ISO   = 2'd0,
    ENC_MAC   = 2'd1,
    ENC_UTF8  = 2'd2,
    ENC_SPARE = 2'd3
  } enc_t;

  typedef enum logic [1:0] {
    KIND_ASCII = 2'd0,
    KIND_TABLE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam logic [7:0] QMARK = 8'h3F;
  localparam logic [1:0] REG_SOURCE_ENCODING = 2'd0;
  localparam int unsigned RowCount = 97;
  localparam int unsigned HiRow = 65;

  typedef logic [6:0] row_t;

  // MacRoman code to table row; bit 7 of the result flags a hit.
  function automatic logic [7:0] mac_to_row(input logic [7:0] code);
    logic [7:0] res;
    res = 8'h00;
    case (code)
      8'h7f: res = {1'b1, 7'd0};
      8'hca: res = {1'b1, 7'd1};  8'hc1: res = {1'b1, 7'd2};
      8'ha2: res = {1'b1, 7'd3};  8'ha3: res = {1'b1, 7'd4};
      8'hdb: res = {1'b1, 7'd5};  8'hb4: res = {1'b1, 7'd6};
      8'ha4: res = {1'b1, 7'd8};  8'hac: res = {1'b1, 7'd9};
      8'ha9: res = {1'b1, 7'd10}; 8'hbb: res = {1'b1, 7'd11};
      8'hc7: res = {1'b1, 7'd12}; 8'hc2: res = {1'b1, 7'd13};
      8'hd1: res = {1'b1, 7'd14}; 8'ha8: res = {1'b1, 7'd15};
      8'ha1: res = {1'b1, 7'd17}; 8'hb1: res = {1'b1, 7'd18};
      8'hd5: res = {1'b1, 7'd21}; 8'hb5: res = {1'b1, 7'd22};
      8'ha6: res = {1'b1, 7'd23}; 8'he1: res = {1'b1, 7'd24};
      8'hfc: res = {1'b1, 7'd25}; 8'hbc: res = {1'b1, 7'd27};
      8'hc8: res = {1'b1, 7'd28}; 8'hc0: res = {1'b1, 7'd32};
      8'hcb: res = {1'b1, 7'd33}; 8'he7: res = {1'b1, 7'd34};
      8'he5: res = {1'b1, 7'd35}; 8'hcc: res = {1'b1, 7'd36};
      8'h80: res = {1'b1, 7'd37}; 8'h81: res = {1'b1, 7'd38};
      8'hae: res = {1'b1, 7'd39}; 8'h82: res = {1'b1, 7'd40};
      8'he9: res = {1'b1, 7'd41}; 8'h83: res = {1'b1, 7'd42};
      8'he6: res = {1'b1, 7'd43}; 8'he8: res = {1'b1, 7'd44};
      8'hed: res = {1'b1, 7'd45}; 8'hea: res = {1'b1, 7'd46};
      8'heb: res = {1'b1, 7'd47}; 8'hec: res = {1'b1, 7'd48};
      8'h84: res = {1'b1, 7'd50}; 8'hf1: res = {1'b1, 7'd51};
      8'hee: res = {1'b1, 7'd52}; 8'hef: res = {1'b1, 7'd53};
      8'hcd: res = {1'b1, 7'd54}; 8'h85: res = {1'b1, 7'd55};
      8'haf: res = {1'b1, 7'd57}; 8'hf4: res = {1'b1, 7'd58};
      8'hf2: res = {1'b1, 7'd59}; 8'hf3: res = {1'b1, 7'd60};
      8'h86: res = {1'b1, 7'd61}; 8'ha7: res = {1'b1, 7'd64};
      8'h88: res = {1'b1, 7'd65}; 8'h87: res = {1'b1, 7'd66};
      8'h89: res = {1'b1, 7'd67}; 8'h8b: res = {1'b1, 7'd68};
      8'h8a: res = {1'b1, 7'd69}; 8'h8c: res = {1'b1, 7'd70};
      8'hbe: res = {1'b1, 7'd71}; 8'h8d: res = {1'b1, 7'd72};
      8'h8f: res = {1'b1, 7'd73}; 8'h8e: res = {1'b1, 7'd74};
      8'h90: res = {1'b1, 7'd75}; 8'h91: res = {1'b1, 7'd76};
      8'h93: res = {1'b1, 7'd77}; 8'h92: res = {1'b1, 7'd78};
      8'h94: res = {1'b1, 7'd79}; 8'h95: res = {1'b1, 7'd80};
      8'h96: res = {1'b1, 7'd82}; 8'h98: res = {1'b1, 7'd83};
      8'h97: res = {1'b1, 7'd84}; 8'h99: res = {1'b1, 7'd85};
      8'h9b: res = {1'b1, 7'd86}; 8'h9a: res = {1'b1, 7'd87};
      8'hd6: res = {1'b1, 7'd88}; 8'hbf: res = {1'b1, 7'd89};
      8'h9d: res = {1'b1, 7'd90}; 8'h9c: res = {1'b1, 7'd91};
      8'h9e: res = {1'b1, 7'd92}; 8'h9f: res = {1'b1, 7'd93};
      8'hd8: res = {1'b1, 7'd96};
      // Code 0x00 appears in unused rows but byte0 is always at least 0x80 here.
      default: res = 8'h00;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] row_asm(input row_t r);
    logic [7:0] res;
    res = 8'h00;
    if (r <= 7'd1) begin
      res = 8'h7F;
    end else if (r >= 7'(HiRow)) begin
      case (5'(r - 7'(HiRow)))
        5'd0:  res = 8'h84; 5'd1:  res = 8'h81; 5'd2:  res = 8'h82;
        5'd4:  res = 8'h83; 5'd7:  res = 8'h80; 5'd8:  res = 8'h88;
        5'd9:  res = 8'h85; 5'd10: res = 8'h86; 5'd11: res = 8'h87;
        5'd14: res = 8'h89; 5'd15: res = 8'h8a; 5'd20: res = 8'h8b;
        5'd22: res = 8'h8c; 5'd25: res = 8'h8f; 5'd27: res = 8'h8d;
        5'd28: res = 8'h8e;
        default: res = 8'h00;
      endcase
    end
    return res;
  endfunction

  function automatic logic [15:0] row_acc(input row_t r);
    logic [15:0] res;
    res = 16'h3F00;
    if (r == 7'd0) begin
      res = 16'h7F00;
    end else if (r >= 7'(HiRow)) begin
      case (5'(r - 7'(HiRow)))
        5'd0:  res = 16'h4161; 5'd1:  res = 16'h4261; 5'd2:  res = 16'h4361;
        5'd4:  res = 16'h4861; 5'd7:  res = 16'h4B63; 5'd8:  res = 16'h4165;
        5'd9:  res = 16'h4265; 5'd10: res = 16'h4365; 5'd11: res = 16'h4865;
        5'd14: res = 16'h4369; 5'd15: res = 16'h4869; 5'd20: res = 16'h436F;
        5'd22: res = 16'h486F; 5'd25: res = 16'h4175; 5'd27: res = 16'h4375;
        5'd28: res = 16'h4875;
        default: res = 16'h3F00;
      endcase
    end
    return res;
  endfunction

endpackage

// ----- rtl/lutf_if.sv -----
interface lutf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  modport source (output valid, byte0, byte1, byte2, byte3, input ready);
  modport sink (input valid, byte0, byte1, byte2, byte3, output ready);
endinterface

interface lutf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  asm_char;
  logic [15:0] accent_pair;
  logic [1:0]  char_kind;
  logic [2:0]  bytes_used;
  modport source (output valid, asm_char, accent_pair, char_kind, bytes_used, input ready);
  modport sink (input valid, asm_char, accent_pair, char_kind, bytes_used, output ready);
endinterface

// ----- rtl/latin_utf8_char_transcoder.sv -----
// Latin / UTF-8 character transcoder.
// The input channel carries a beat with a four-byte look-ahead window; the
// output channel returns one beat per input beat holding the assembler code,
// the two-letter accent code, the character kind and the bytes consumed.
// The source encoding (ISO-8859-1, MacRoman, UTF-8) is set through the APB
// register at address 0 and should be changed only while the block is idle.
// Decoding is a single pass of table logic between the input beat and the
// result register, which loads as the beat is taken; one beat can be taken
// in every cycle unless the receiver stalls. The result register is the only
// stage: in.ready is high while it is empty or being drained in the same cycle.
// When the receiver stalls the result is held steady and the input is held
// off until it is taken. Reset empties the result register and sets the
// encoding to ISO-8859-1.
module latin_utf8_char_transcoder
  import lutf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lutf_in_if.sink     in_ch,
  lutf_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  enc_t        enc_r;
  logic        vld_r;
  logic [7:0]  asm_r;
  logic [15:0] acc_r;
  kind_t       kind_r;
  logic [2:0]  used_r;

  logic        found;
  row_t        row;
  logic [7:0]  asm_nxt;
  logic [15:0] acc_nxt;
  kind_t       kind_nxt;
  logic [2:0]  used_nxt;
  logic [7:0]  mac_hit;
  logic [7:0]  b0, b1, b2, b3;
  logic        take;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {30'd0, enc_r};
  assign b0 = in_ch.byte0;
  assign b1 = in_ch.byte1;
  assign b2 = in_ch.byte2;
  assign b3 = in_ch.byte3;
  assign mac_hit = mac_to_row(b0);

  always_comb begin
    found    = 1'b0;
    row      = '0;
    used_nxt = 3'd1;
    kind_nxt = KIND_ERROR;
    asm_nxt  = QMARK;
    acc_nxt  = {8'h00, QMARK};
    if (b0 >= 8'h20 && b0 <= 8'h7F) begin
      kind_nxt = KIND_ASCII;
      asm_nxt  = b0;
      acc_nxt  = {8'h00, b0};
    end else if ((enc_r == ENC_ISO || enc_r == ENC_MAC) && b0[7] &&
                 b1 != 8'h00 && !b1[7]) begin
      if (enc_r == ENC_ISO) begin
        if (b0 >= 8'hA0) begin
          found = 1'b1;
          row   = 7'(b0 - 8'h9F);
        end
      end else begin
        found = mac_hit[7];
        row   = mac_hit[6:0];
      end
    end else if (enc_r == ENC_UTF8 && b0 >= 8'hC2 && b0 <= 8'hF4 && b1[7]) begin
      used_nxt = 3'd2;
      if (b0 >= 8'hE0 && b2[7]) begin
        used_nxt = 3'd3;
        if (b0 >= 8'hF0 && b3[7]) used_nxt = 3'd4;
      end
      // Only two-byte C2/C3 forms and the three-byte block character exist.
      if (used_nxt == 3'd2 && b0 == 8'hC2 && b1 >= 8'hA0 && b1 <= 8'hBF) begin
        found = 1'b1;
        row   = 7'(b1 - 8'h9F);
      end else if (used_nxt == 3'd2 && b0 == 8'hC3 && b1 <= 8'hBF) begin
        found = 1'b1;
        row   = 7'(b1 - 8'h5F);
      end else if (used_nxt == 3'd3 && b0 == 8'hE2 && b1 == 8'h96 && b2 == 8'h88) begin
        found = 1'b1;
        row   = '0;
      end
    end
    if (found) begin
      kind_nxt = KIND_TABLE;
      asm_nxt  = row_asm(row);
      acc_nxt  = row_acc(row);
    end
  end

  assign in_ch.ready = !vld_r || out_ch.ready;
  assign take = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_r <= ENC_ISO;
      vld_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_SOURCE_ENCODING) begin
        enc_r <= enc_t'(cfg_pwdata[1:0]);
      end
      if (take) vld_r <= 1'b1;
      else if (out_ch.ready) vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      asm_r  <= asm_nxt;
      acc_r  <= acc_nxt;
      kind_r <= kind_nxt;
      used_r <= used_nxt;
    end
  end

  assign out_ch.valid       = vld_r;
  assign out_ch.asm_char    = asm_r;
  assign out_ch.accent_pair = acc_r;
  assign out_ch.char_kind   = kind_r;
  assign out_ch.bytes_used  = used_r;

`ifndef SYNTHESIS
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (used_r >= 3'd1 && used_r <= 3'd4))
    else $error("bytes_used out of range");
  a_ascii_one: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && kind_r == KIND_ASCII) |-> (used_r == 3'd1 && acc_r[15:8] == 8'h00))
    else $error("ascii result malformed");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !out_ch.ready) |=> (vld_r && $stable(asm_r) && $stable(used_r)))
    else $error("stalled result changed");
  a_error_q: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && kind_r == KIND_ERROR) |-> asm_r == QMARK)
    else $error("error result not question mark");
`endif

endmodule

// ----- sim/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lutf_pkg::*;

  typedef struct packed {
    logic [7:0]  asm_char;
    logic [15:0] accent_pair;
    logic [1:0]  char_kind;
    logic [2:0]  bytes_used;
  } char_res_t;

  // Table row order: MacRoman code per row, row 0 is DEL, row r is ISO 0x9F+r.
  localparam logic [7:0] MAC_CODES [0:96] = '{
    8'h7f,
    8'hca, 8'hc1, 8'ha2, 8'ha3, 8'hdb, 8'hb4, 8'h00, 8'ha4,
    8'hac, 8'ha9, 8'hbb, 8'hc7, 8'hc2, 8'hd1, 8'ha8, 8'h00,
    8'ha1, 8'hb1, 8'h00, 8'h00, 8'hd5, 8'hb5, 8'ha6, 8'he1,
    8'hfc, 8'h00, 8'hbc, 8'hc8, 8'h00, 8'h00, 8'h00, 8'hc0,
    8'hcb, 8'he7, 8'he5, 8'hcc, 8'h80, 8'h81, 8'hae, 8'h82,
    8'he9, 8'h83, 8'he6, 8'he8, 8'hed, 8'hea, 8'heb, 8'hec,
    8'h00, 8'h84, 8'hf1, 8'hee, 8'hef, 8'hcd, 8'h85, 8'h00,
    8'haf, 8'hf4, 8'hf2, 8'hf3, 8'h86, 8'h00, 8'h00, 8'ha7,
    8'h88, 8'h87, 8'h89, 8'h8b, 8'h8a, 8'h8c, 8'hbe, 8'h8d,
    8'h8f, 8'h8e, 8'h90, 8'h91, 8'h93, 8'h92, 8'h94, 8'h95,
    8'h00, 8'h96, 8'h98, 8'h97, 8'h99, 8'h9b, 8'h9a, 8'hd6,
    8'hbf, 8'h9d, 8'h9c, 8'h9e, 8'h9f, 8'h00, 8'h00, 8'hd8
  };
  localparam logic [7:0] HI_ASM [0:31] = '{
    8'h84, 8'h81, 8'h82, 8'h00, 8'h83, 8'h00, 8'h00, 8'h80,
    8'h88, 8'h85, 8'h86, 8'h87, 8'h00, 8'h00, 8'h89, 8'h8a,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h8b, 8'h00, 8'h8c, 8'h00,
    8'h00, 8'h8f, 8'h00, 8'h8d, 8'h8e, 8'h00, 8'h00, 8'h00
  };
  localparam logic [15:0] HI_ACC [0:31] = '{
    16'h4161, 16'h4261, 16'h4361, 16'h3F00, 16'h4861, 16'h3F00, 16'h3F00, 16'h4B63,
    16'h4165, 16'h4265, 16'h4365, 16'h4865, 16'h3F00, 16'h3F00, 16'h4369, 16'h4869,
    16'h3F00, 16'h3F00, 16'h3F00, 16'h3F00, 16'h436F, 16'h3F00, 16'h486F, 16'h3F00,
    16'h3F00, 16'h4175, 16'h3F00, 16'h4375, 16'h4875, 16'h3F00, 16'h3F00, 16'h3F00
  };

  function automatic logic [31:0] utf8_of_row(input int r);
    int iso;
    if (r == 0) return 32'hE29688;
    iso = 'h9F + r;
    if (iso < 'hC0) return 32'hC200 | iso;
    return 32'hC300 | (iso - 'h40);
  endfunction

  function automatic char_res_t transcode(input enc_t enc, input logic [7:0] b0,
                                          input logic [7:0] b1, input logic [7:0] b2,
                                          input logic [7:0] b3);
    char_res_t res;
    bit hit;
    int row;
    logic [31:0] code;
    res = '{asm_char: QMARK, accent_pair: 16'h003F, char_kind: KIND_ERROR, bytes_used: 3'd1};
    hit = 0;
    row = 0;
    if (b0 >= 8'h20 && b0 <= 8'h7F) begin
      res = '{asm_char: b0, accent_pair: {8'h00, b0}, char_kind: KIND_ASCII, bytes_used: 3'd1};
    end else if ((enc == ENC_ISO || enc == ENC_MAC) && b0[7] && b1 != 0 && !b1[7]) begin
      if (enc == ENC_ISO) begin
        if (b0 >= 8'hA0) begin
          hit = 1;
          row = b0 - 8'h9F;
        end
      end else begin
        for (int r = 0; r < RowCount && !hit; r++) begin
          if (MAC_CODES[r] == b0) begin
            hit = 1;
            row = r;
          end
        end
      end
    end else if (enc == ENC_UTF8 && b0 >= 8'hC2 && b0 <= 8'hF4 && b1[7]) begin
      code = {16'h0, b0, b1};
      res.bytes_used = 3'd2;
      if (b0 >= 8'hE0 && b2[7]) begin
        code = {code[23:0], b2};
        res.bytes_used = 3'd3;
        if (b0 >= 8'hF0 && b3[7]) begin
          code = {code[23:0], b3};
          res.bytes_used = 3'd4;
        end
      end
      for (int r = 0; r < RowCount && !hit; r++) begin
        if (utf8_of_row(r) == code) begin
          hit = 1;
          row = r;
        end
      end
    end
    if (hit) begin
      res.char_kind = KIND_TABLE;
      res.asm_char = (row <= 1) ? 8'h7F : (row < HiRow ? 8'h00 : HI_ASM[row - HiRow]);
      res.accent_pair = (row == 0) ? 16'h7F00 :
                        (row < HiRow ? 16'h3F00 : HI_ACC[row - HiRow]);
    end
    return res;
  endfunction

  class char_scoreboard;
    char_res_t pending[$];
    int mismatches;
    int checked;
    function void note_window(enc_t enc, logic [7:0] b0, logic [7:0] b1,
                              logic [7:0] b2, logic [7:0] b3);
      pending.push_back(transcode(enc, b0, b1, b2, b3));
    endfunction
    function void check_result(char_res_t got);
      char_res_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want asm %h acc %h kind %0d used %0d, got %h %h %0d %0d",
                   want.asm_char, want.accent_pair, want.char_kind, want.bytes_used,
                   got.asm_char, got.accent_pair, got.char_kind, got.bytes_used);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  lutf_in_if in_ch();
  lutf_out_if out_ch();

  latin_utf8_char_transcoder i_dut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  always #2 clk = ~clk;

  char_scoreboard board = new();
  enc_t cur_enc = ENC_ISO;
  int stall_mode = 0;
  bit done_all = 0;

  initial begin
    in_ch.valid = 0;
    {in_ch.byte0, in_ch.byte1, in_ch.byte2, in_ch.byte3} = '0;
    out_ch.ready = 0;
  end

  // Receiver: stall pattern changes every so often, including stretches with none.
  always @(negedge clk) begin
    if (($urandom % 64) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom % 4) != 0;
      2: out_ch.ready <= ($urandom % 2) != 0;
      default: out_ch.ready <= ($urandom % 8) == 0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result('{out_ch.asm_char, out_ch.accent_pair, out_ch.char_kind,
                           out_ch.bytes_used});
  end

  task automatic write_encoding(input enc_t enc);
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= REG_SOURCE_ENCODING;
    cfg_pwdata <= 32'(enc);
    @(negedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    cur_enc = enc;
  endtask

  task automatic drain_results();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  // One window beat; valid stays high when the next beat follows directly.
  task automatic send_window(input logic [7:0] b0, b1, b2, b3, input bit keep);
    in_ch.valid <= 1;
    {in_ch.byte0, in_ch.byte1, in_ch.byte2, in_ch.byte3} <= {b0, b1, b2, b3};
    do @(posedge clk); while (!in_ch.ready);
    board.note_window(cur_enc, b0, b1, b2, b3);
    @(negedge clk);
    if (!keep) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  task automatic random_window(input bit keep);
    logic [7:0] b [4];
    int r, pick;
    for (int k = 0; k < 4; k++) b[k] = 8'($urandom);
    pick = $urandom_range(0, 9);
    r = $urandom_range(0, 96);
    if (pick < 3) begin
      b[0] = 8'($urandom_range(8'h20, 8'h7F));
    end else if (pick < 8) begin
      if (cur_enc == ENC_UTF8) begin
        {b[0], b[1], b[2]} = 24'(utf8_of_row(r));
        if (r != 0) begin
          {b[0], b[1]} = 16'(utf8_of_row(r));
          b[2] = ($urandom % 2) ? cont_byte() : 8'($urandom_range(0, 127));
        end else begin
          b[3] = cont_byte();
        end
        if ($urandom % 4 == 0) b[$urandom_range(1, 3)] = cont_byte();
      end else begin
        b[0] = (cur_enc == ENC_MAC) ? MAC_CODES[r] : 8'($urandom_range(8'h80, 8'hFF));
        if (b[0] == 0) b[0] = 8'($urandom_range(8'h80, 8'hFF));
        b[1] = ($urandom % 8) ? 8'($urandom_range(1, 127)) : b[1];
      end
    end
    send_window(b[0], b[1], b[2], b[3], keep);
  endtask

  task automatic directed_windows();
    send_window(8'h00, 8'h00, 8'h00, 8'h00, 0);
    send_window(8'h1F, 8'h41, 8'h00, 8'h00, 0);
    send_window(8'h20, 8'hFF, 8'hFF, 8'hFF, 0);
    send_window(8'h7F, 8'h00, 8'h00, 8'h00, 0);
    send_window(8'h80, 8'h00, 8'h00, 8'h00, 0);
    send_window(8'hA0, 8'h7F, 8'h00, 8'h00, 0);
    send_window(8'hE9, 8'h01, 8'h00, 8'h00, 0);
    send_window(8'hFF, 8'h80, 8'h00, 8'h00, 0);
    send_window(8'hC3, 8'hA9, 8'h80, 8'h80, 0);
    send_window(8'hC2, 8'hA0, 8'h00, 8'h00, 0);
    send_window(8'hC1, 8'hA0, 8'h00, 8'h00, 0);
    send_window(8'hC2, 8'h41, 8'h00, 8'h00, 0);
    send_window(8'hE2, 8'h96, 8'h88, 8'hFF, 0);
    send_window(8'hE2, 8'h96, 8'h08, 8'h00, 0);
    send_window(8'hF4, 8'h8F, 8'hBF, 8'hBF, 0);
    send_window(8'hF5, 8'h80, 8'h80, 8'h80, 0);
    send_window(8'hF0, 8'h90, 8'h80, 8'h7F, 0);
    send_window(8'hD8, 8'h41, 8'h00, 8'h00, 0);
  endtask

  initial begin
    enc_t order [6] = '{ENC_ISO, ENC_MAC, ENC_UTF8, ENC_SPARE, ENC_UTF8, ENC_ISO};
    int burst;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    for (int e = 0; e < 4; e++) begin
      write_encoding(enc_t'(e));
      directed_windows();
      drain_results();
    end
    foreach (order[p]) begin
      write_encoding(order[p]);
      for (int n = 0; n < 220; ) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst; k++) random_window(k != burst - 1);
        n += burst;
        if (n > 110 && n <= 110 + burst) drain_results();
        else repeat ($urandom_range(0, 5)) @(negedge clk);
      end
      drain_results();
    end
    $display("covered %0d windows over all four encoding settings, with bursts and stalls",
             board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end
endmodule
